### rtl/jitter_buffer_upsampler_by_three_top_macros.svh
`ifndef JITTER_BUFFER_UPSAMPLER_BY_THREE_TOP_MACROS_SVH
`define JITTER_BUFFER_UPSAMPLER_BY_THREE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define JBUP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jbup check failed");

// next-cycle implication
`define JBUP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jbup check failed");

`endif

### rtl/jbup_pkg.sv
package jbup_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 4096;
	localparam int unsigned LEVEL_W        = 12;
	localparam int unsigned SAMPLE_W       = 12;
	localparam int unsigned FREE_W         = 14;
	localparam int unsigned PACK_W         = 24;

	typedef logic [1:0]                 cmd_t;
	typedef logic [7:0]                 byte_t;
	typedef logic [PACK_W-1:0]          pack_t;
	typedef logic [LEVEL_W-1:0]         level_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [FREE_W-1:0]          free_t;
	typedef logic [2:0]                 phase_t;

	localparam cmd_t CMD_PUSH  = 2'd0;
	localparam cmd_t CMD_PULL  = 2'd1;
	localparam cmd_t CMD_FLUSH = 2'd2;

	localparam level_t START_LEVEL_RST = 12'd300;
	// subtracting 2048 from a 12-bit offset-binary value flips its top bit
	localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 12'h800;

	localparam phase_t PHASE_HIGH = 3'd0;
	localparam phase_t PHASE_LOW  = 3'd3;
	localparam phase_t PHASE_LAST = 3'd5;

endpackage

### rtl/jbup_ifs.sv
interface jbup_pack_if;
	import jbup_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  command;
	byte_t byte_0;
	byte_t byte_1;
	byte_t byte_2;
	logic  block_end;

	modport source (output valid, command, byte_0, byte_1, byte_2, block_end, input ready);
	modport sink   (input valid, command, byte_0, byte_1, byte_2, block_end, output ready);
	modport mon    (input valid, ready, command, byte_0, byte_1, byte_2, block_end);
endinterface

interface jbup_sample_if;
	import jbup_pkg::*;

	logic    valid;
	logic    ready;
	logic    sample_valid;
	sample_t sample;
	free_t   free_space_bytes;
	logic    pack_dropped;

	modport source (output valid, sample_valid, sample, free_space_bytes, pack_dropped,
		input ready);
	modport sink   (input valid, sample_valid, sample, free_space_bytes, pack_dropped,
		output ready);
	modport mon    (input valid, ready, sample_valid, sample, free_space_bytes, pack_dropped);
endinterface

### rtl/jbup_store.sv
module jbup_store #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  jbup_pkg::pack_t wdata,
	input  logic [AW-1:0]   raddr,
	output jbup_pkg::pack_t rdata
);
	import jbup_pkg::*;

	pack_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-through so a pack pushed into an empty fifo is read back at once
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/jitter_buffer_upsampler_by_three_top.sv
// channel    | dir | payload                                         | request taken when
// pack_ch    | in  | command, byte_0..byte_2, block_end              | valid && ready
// sample_ch  | out | sample_valid, sample, free_space_bytes, dropped | valid && ready
// cfg        | in  | cfg_wdata (start level)                         | cfg_we
//
// one request per cycle unless the result stalls; each passes an input register, then a result register
// the pack at the read pointer is prefetched from the single-port-write store,
// so a pop needs no extra cycle
// reset clears pointers, fill, phase and playback, start level goes to 300;
// the pack store itself is not cleared and needs no clearing pass
// pack_ch.ready drops only when both stages hold requests and the result is not taken
module jitter_buffer_upsampler_by_three_top #(
	parameter int unsigned FIFO_DEPTH = jbup_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  jbup_pkg::level_t cfg_wdata,
	jbup_pack_if.sink        pack_ch,
	jbup_sample_if.source    sample_ch
);
	import jbup_pkg::*;

	localparam int unsigned AW = $clog2(FIFO_DEPTH);
	localparam int unsigned FW = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned CW = (FW > LEVEL_W) ? FW : LEVEL_W;
	localparam int unsigned MW = ((FW + 2) > FREE_W) ? (FW + 2) : FREE_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	// state
	level_t          start_level_q;
	logic [AW-1:0]   rp_q, wp_q;
	logic [FW-1:0]   fill_q;
	phase_t          phase_q;
	logic            playing_q;
	logic [11:0]     held_low_q;

	// stages
	logic            valid_s1;
	cmd_t            command_s1;
	pack_t           pack_s1;
	logic            block_end_s1;
	logic            valid_s2;
	logic            sample_valid_s2;
	sample_t         sample_s2;
	free_t           free_s2;
	logic            dropped_s2;

	// next state
	logic [AW-1:0]   rp_d, wp_d, raddr;
	logic [FW-1:0]   fill_d;
	phase_t          phase_d;
	logic            playing_d;
	logic [11:0]     held_low_d;
	logic            wr_en, sv_d, dropped_d;
	sample_t         sample_d;
	logic [MW-1:0]   spare, spare_x3;
	pack_t           rd_data;
	logic            advance_s2, fire;

	assign advance_s2    = !valid_s2 || sample_ch.ready;
	assign pack_ch.ready = !valid_s1 || advance_s2;
	assign fire          = valid_s1 && advance_s2;

	always_comb begin
		rp_d       = rp_q;
		wp_d       = wp_q;
		fill_d     = fill_q;
		phase_d    = phase_q;
		playing_d  = playing_q;
		held_low_d = held_low_q;
		wr_en      = 1'b0;
		sv_d       = 1'b0;
		sample_d   = '0;
		dropped_d  = 1'b0;
		unique case (command_s1)
			CMD_PUSH: begin
				if (fill_q == FW'(FIFO_DEPTH)) begin
					dropped_d = 1'b1;
				end else begin
					wr_en  = 1'b1;
					wp_d   = bump(wp_q);
					fill_d = fill_q + 1'b1;
				end
				if (block_end_s1 && !playing_q && (CW'(fill_d) > CW'(start_level_q))) begin
					playing_d = 1'b1;
				end
			end
			CMD_PULL: begin
				if (playing_q) begin
					if (phase_q == PHASE_HIGH) begin
						if (fill_q == '0) begin
							playing_d = 1'b0;
						end else begin
							rp_d       = bump(rp_q);
							fill_d     = fill_q - 1'b1;
							held_low_d = rd_data[11:0];
							sample_d   = sample_t'(rd_data[23:12] ^ SAMPLE_OFFSET);
							sv_d       = 1'b1;
						end
					end else begin
						sample_d = (phase_q == PHASE_LOW) ?
							sample_t'(held_low_q ^ SAMPLE_OFFSET) : '0;
						sv_d     = 1'b1;
					end
					if (sv_d) begin
						phase_d = (phase_q == PHASE_LAST) ? PHASE_HIGH : phase_q + 1'b1;
					end
				end
			end
			CMD_FLUSH: begin
				rp_d       = '0;
				wp_d       = '0;
				fill_d     = '0;
				phase_d    = PHASE_HIGH;
				playing_d  = 1'b0;
				held_low_d = '0;
			end
			default: begin
			end
		endcase
	end

	// free bytes = free entries * 3
	assign spare    = MW'(FIFO_DEPTH) - MW'(fill_d);
	assign spare_x3 = spare + (spare << 1);

	// keep the store read port on the next read pointer
	assign raddr = fire ? rp_d : rp_q;

	jbup_store #(
		.DEPTH (FIFO_DEPTH),
		.AW    (AW)
	) u_jbup_store (
		.clk   (clk),
		.we    (fire && wr_en),
		.waddr (wp_q),
		.wdata (pack_s1),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= START_LEVEL_RST;
		end else if (cfg_we) begin
			start_level_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q       <= '0;
			wp_q       <= '0;
			fill_q     <= '0;
			phase_q    <= PHASE_HIGH;
			playing_q  <= 1'b0;
			held_low_q <= '0;
		end else if (fire) begin
			rp_q       <= rp_d;
			wp_q       <= wp_d;
			fill_q     <= fill_d;
			phase_q    <= phase_d;
			playing_q  <= playing_d;
			held_low_q <= held_low_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pack_ch.ready) begin
				valid_s1 <= pack_ch.valid;
			end
			if (advance_s2) begin
				valid_s2 <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pack_ch.valid && pack_ch.ready) begin
			command_s1   <= pack_ch.command;
			pack_s1      <= {pack_ch.byte_2, pack_ch.byte_1, pack_ch.byte_0};
			block_end_s1 <= pack_ch.block_end;
		end
		if (fire) begin
			sample_valid_s2 <= sv_d;
			sample_s2       <= sample_d;
			free_s2         <= spare_x3[FREE_W-1:0];
			dropped_s2      <= dropped_d;
		end
	end

	assign sample_ch.valid            = valid_s2;
	assign sample_ch.sample_valid     = sample_valid_s2;
	assign sample_ch.sample           = sample_s2;
	assign sample_ch.free_space_bytes = free_s2;
	assign sample_ch.pack_dropped     = dropped_s2;

endmodule

### rtl/jbup_checker.sv
module jbup_checker (
	input logic           clk,
	input logic           arst_n,
	jbup_sample_if.source sample_ch
);
	`include "jitter_buffer_upsampler_by_three_top_macros.svh"

	// results without a sample carry a zero sample
	`JBUP_ASSERT_NOW(a_idle_sample_zero, sample_ch.valid && !sample_ch.sample_valid, sample_ch.sample == '0)
	// a dropped pack means the fifo was full
	`JBUP_ASSERT_NOW(a_drop_when_full, sample_ch.valid && sample_ch.pack_dropped, sample_ch.free_space_bytes == '0)
	// a dropped push never yields a sample
	`JBUP_ASSERT_NOW(a_drop_no_sample, sample_ch.valid && sample_ch.pack_dropped, !sample_ch.sample_valid)
	// a stalled result holds
	`JBUP_ASSERT_NEXT(a_stall_hold, sample_ch.valid && !sample_ch.ready, sample_ch.valid && $stable(sample_ch.sample) && $stable(sample_ch.free_space_bytes))

endmodule

bind jitter_buffer_upsampler_by_three_top jbup_checker u_jbup_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.sample_ch (sample_ch)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import jbup_pkg::*;

	localparam int unsigned DEPTH      = FIFO_DEPTH_DEF;
	localparam int unsigned LIMIT      = 300000;
	localparam int unsigned DRAIN_WAIT = 8;
	localparam int unsigned SHOW_MAX   = 10;
	localparam cmd_t        CMD_SPARE  = 2'd3;
	localparam level_t      LEVEL_MAX  = 12'hFFF;

	typedef struct packed {
		cmd_t  command;
		byte_t byte_2;
		byte_t byte_1;
		byte_t byte_0;
		logic  block_end;
	} pack_req_t;

	typedef struct packed {
		logic    sample_valid;
		sample_t sample;
		free_t   free_space_bytes;
		logic    pack_dropped;
	} playout_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	level_t cfg_wdata;

	jbup_pack_if   pack_ch ();
	jbup_sample_if sample_ch ();

	jitter_buffer_upsampler_by_three_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pack_ch   (pack_ch),
		.sample_ch (sample_ch)
	);

	// mirror of the buffer state
	pack_t       mirror_store [DEPTH];
	int unsigned mirror_rd;
	int unsigned mirror_wr;
	int unsigned mirror_fill;
	phase_t      mirror_phase;
	logic        mirror_playing;
	logic [11:0] mirror_low;
	level_t      mirror_level = START_LEVEL_RST;

	pack_req_t pack_requests [$];
	playout_t  predicted_samples [$];
	playout_t  got_sample;
	playout_t  want_sample;

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned stall_cycles   = 0;
	int unsigned stall_req_id   = 0;
	int unsigned stall_seen_id  = 0;
	int unsigned stall_left     = 0;
	int unsigned cycle_count    = 0;
	int unsigned mismatch_count = 0;
	int unsigned error_count    = 0;
	int unsigned sample_count   = 0;
	int unsigned drop_count     = 0;
	int unsigned cmd_count [4]  = '{default: 0};

	always #5 clk = ~clk;

	function automatic void clear_mirror();
		mirror_rd      = 0;
		mirror_wr      = 0;
		mirror_fill    = 0;
		mirror_phase   = PHASE_HIGH;
		mirror_playing = 1'b0;
		mirror_low     = '0;
	endfunction

	function automatic playout_t predict_playout(pack_req_t req);
		playout_t res;
		pack_t    word;
		res = '0;
		case (req.command)
			CMD_PUSH: begin
				if (mirror_fill >= DEPTH) begin
					res.pack_dropped = 1'b1;
				end else begin
					mirror_store[mirror_wr] = {req.byte_2, req.byte_1, req.byte_0};
					mirror_wr = (mirror_wr + 1) % DEPTH;
					mirror_fill++;
				end
				// the start check runs even when the pack was dropped
				if (req.block_end && !mirror_playing && mirror_fill > mirror_level)
					mirror_playing = 1'b1;
			end
			CMD_PULL: begin
				if (mirror_playing) begin
					if (mirror_phase != PHASE_HIGH) begin
						res.sample_valid = 1'b1;
						if (mirror_phase == PHASE_LOW)
							res.sample = mirror_low - SAMPLE_OFFSET;
					end else if (mirror_fill == 0) begin
						// underrun stops playback, phase stays put
						mirror_playing = 1'b0;
					end else begin
						word = mirror_store[mirror_rd];
						mirror_rd = (mirror_rd + 1) % DEPTH;
						mirror_fill--;
						mirror_low = word[11:0];
						res.sample = word[23:12] - SAMPLE_OFFSET;
						res.sample_valid = 1'b1;
					end
					if (res.sample_valid)
						mirror_phase = (mirror_phase == PHASE_LAST) ? PHASE_HIGH : mirror_phase + 1'b1;
				end
			end
			CMD_FLUSH: clear_mirror();
			default: ;
		endcase
		res.free_space_bytes = free_t'((DEPTH - mirror_fill) * 3);
		return res;
	endfunction

	// sender: holds a request until it is taken, then offers the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			pack_ch.valid <= 1'b0;
		end else begin
			if (pack_ch.valid && pack_ch.ready) begin
				cmd_count[pack_ch.command]++;
				predicted_samples.push_back(predict_playout({pack_ch.command, pack_ch.byte_2,
					pack_ch.byte_1, pack_ch.byte_0, pack_ch.block_end}));
			end
			if (!pack_ch.valid || pack_ch.ready) begin
				if (pack_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					pack_ch.valid     <= 1'b1;
					pack_ch.command   <= pack_requests[0].command;
					pack_ch.byte_0    <= pack_requests[0].byte_0;
					pack_ch.byte_1    <= pack_requests[0].byte_1;
					pack_ch.byte_2    <= pack_requests[0].byte_2;
					pack_ch.block_end <= pack_requests[0].block_end;
					void'(pack_requests.pop_front());
				end else begin
					pack_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_ch.ready <= 1'b0;
		end else if (stall_seen_id != stall_req_id) begin
			stall_seen_id   <= stall_req_id;
			stall_left      <= stall_cycles;
			sample_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left      <= stall_left - 1;
			sample_ch.ready <= 1'b0;
		end else begin
			sample_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			got_sample = {sample_ch.sample_valid, sample_ch.sample,
				sample_ch.free_space_bytes, sample_ch.pack_dropped};
			if (predicted_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_MAX)
					$display("%0t: unexpected result valid=%b sample=%0d free=%0d dropped=%b",
						$time, got_sample.sample_valid, got_sample.sample,
						got_sample.free_space_bytes, got_sample.pack_dropped);
			end else begin
				want_sample = predicted_samples.pop_front();
				sample_count += want_sample.sample_valid;
				drop_count   += want_sample.pack_dropped;
				if (got_sample !== want_sample) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_MAX)
						$display("%0t: mismatch exp valid=%b sample=%0d free=%0d dropped=%b, %s",
							$time, want_sample.sample_valid, want_sample.sample,
							want_sample.free_space_bytes, want_sample.pack_dropped,
							$sformatf("got valid=%b sample=%0d free=%0d dropped=%b",
								got_sample.sample_valid, got_sample.sample,
								got_sample.free_space_bytes, got_sample.pack_dropped));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_request(cmd_t cmd, pack_t pk, logic be);
		pack_requests.push_back('{cmd, pk[23:16], pk[15:8], pk[7:0], be});
	endtask

	task automatic push_packs(int unsigned n, logic be_last);
		for (int unsigned i = 0; i < n; i++)
			queue_request(CMD_PUSH, pack_t'($urandom), be_last && (i == n - 1));
	endtask

	// block_end and bytes on a pull are don't-care, so keep them random
	task automatic pull_samples(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			queue_request(CMD_PULL, pack_t'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic random_traffic(int unsigned n);
		int unsigned left;
		int unsigned roll;
		int unsigned run;
		cmd_t        cmd;
		left = n;
		while (left > 0) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				cmd = cmd_t'($urandom_range(3));
				queue_request(cmd, pack_t'($urandom), 1'($urandom_range(1)));
				if (cmd != CMD_SPARE)
					left--;
			end else begin
				// pushes come in blocks of 1 to 6 packs, pulls in runs of 1 to 16
				if (roll < 34) begin
					run = $urandom_range(1, 6);
					push_packs(run, $urandom_range(3) != 0);
				end else begin
					run = $urandom_range(1, 16);
					pull_samples(run);
				end
				left = (run >= left) ? 0 : left - run;
			end
		end
	endtask

	// sampled between edges so the driver and monitor updates have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pack_requests.size() != 0 || pack_ch.valid || predicted_samples.size() != 0);
	endtask

	task automatic set_start_level(level_t lvl);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= lvl;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mirror_level = lvl;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = START_LEVEL_RST;
		pack_ch.valid     = 1'b0;
		pack_ch.command   = CMD_PUSH;
		pack_ch.byte_0    = '0;
		pack_ch.byte_1    = '0;
		pack_ch.byte_2    = '0;
		pack_ch.block_end = 1'b0;
		sample_ch.ready   = 1'b0;
		tx_idle_pct       = 6;
		rx_idle_pct       = 78;
		clear_mirror();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset start level: quiet commands, then the exact threshold
		queue_request(CMD_PULL, pack_t'($urandom), 1'b1);
		queue_request(CMD_SPARE, pack_t'($urandom), 1'b1);
		queue_request(CMD_FLUSH, pack_t'($urandom), 1'b1);
		queue_request(CMD_PUSH, 24'h000000, 1'b1);
		queue_request(CMD_FLUSH, pack_t'($urandom), 1'b0);
		push_packs(START_LEVEL_RST, 1'b1);
		pull_samples(1);
		push_packs(1, 1'b1);
		pull_samples(14);
		queue_request(CMD_FLUSH, pack_t'($urandom), 1'b0);
		pull_samples(1);
		wait_drained();

		// sample extremes, then pull past the end of the data
		set_start_level('0);
		queue_request(CMD_PUSH, 24'h000000, 1'b0);
		queue_request(CMD_PUSH, 24'hFFFFFF, 1'b0);
		queue_request(CMD_PUSH, 24'h800800, 1'b0);
		queue_request(CMD_PUSH, 24'h7FF7FF, 1'b1);
		pull_samples(26);
		random_traffic(400);
		wait_drained();

		tx_idle_pct = 78;
		rx_idle_pct = 6;
		set_start_level(level_t'($urandom_range(1, 12)));
		random_traffic(400);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_start_level(level_t'($urandom_range(1, 12)));
		random_traffic(200);
		wait_drained();
		stall_cycles = 300;
		stall_req_id++;
		random_traffic(200);
		wait_drained();

		// top start level: a short buffer never starts playback
		set_start_level(LEVEL_MAX);
		push_packs(8, 1'b1);
		pull_samples(4);
		queue_request(CMD_FLUSH, pack_t'($urandom), 1'b1);
		pull_samples(1);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		if (predicted_samples.size() != 0)
			error_count++;
		$display("run: %0d push, %0d pull, %0d flush, %0d spare requests; %0d samples, %0d drops",
			cmd_count[CMD_PUSH], cmd_count[CMD_PULL], cmd_count[CMD_FLUSH],
			cmd_count[CMD_SPARE], sample_count, drop_count);
		$display("start levels 300, 0, two small ones and 4095; one long output stall; %0d bad",
			mismatch_count + error_count);
		if (mismatch_count == 0 && error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/jbup_pkg.sv
rtl/jbup_ifs.sv
rtl/jbup_store.sv
rtl/jitter_buffer_upsampler_by_three_top.sv
rtl/jbup_checker.sv
tb/tb_top.sv
